// ----- rtl/core/im2col_pkg.sv -----
// im2col_pkg: shared types, widths and register map of the im2col patch address generator
// no dependencies; used by im2col_addr_pipe and im2col_patch_address_generator_unit
`default_nettype none

package im2col_pkg;

  localparam int MAX_KERNEL_DEF    = 8;
  localparam int DILATION_ROWS_DEF = 1;
  localparam int DILATION_COLS_DEF = 1;

  localparam int PLANE_W = 16;
  localparam int POS_W   = 12;
  localparam int TAP_W   = 3;
  localparam int TAPI_W  = 6;
  localparam int ADDR_W  = 40;
  localparam int KER_W   = 4;
  localparam int STR_W   = 5;
  localparam int PAD_W   = 4;
  localparam int IMG_W   = 13;

  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd0;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd1;
  localparam logic [2:0] REG_STRIDE_ROWS   = 3'd2;
  localparam logic [2:0] REG_STRIDE_COLS   = 3'd3;
  localparam logic [2:0] REG_PAD_ROWS      = 3'd4;
  localparam logic [2:0] REG_PAD_COLS      = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd6;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd7;

  typedef struct packed {
    logic [PLANE_W-1:0] plane_index;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [TAP_W-1:0]   tap_row;
    logic [TAP_W-1:0]   tap_col;
    logic               last;
  } tap_t;

  typedef struct packed {
    logic [KER_W-1:0] kernel_width;
    logic [STR_W-1:0] stride_rows;
    logic [STR_W-1:0] stride_cols;
    logic [PAD_W-1:0] pad_rows;
    logic [PAD_W-1:0] pad_cols;
    logic [IMG_W-1:0] image_height;
    logic [IMG_W-1:0] image_width;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/im2col_addr_pipe.sv -----
// im2col_addr_pipe: three-stage address pipeline, one kernel tap per cycle with backpressure
// depends on im2col_pkg (tap_t, cfg_t, widths)
`default_nettype none

module im2col_addr_pipe #(
  parameter int DILATION_ROWS = im2col_pkg::DILATION_ROWS_DEF,
  parameter int DILATION_COLS = im2col_pkg::DILATION_COLS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  im2col_pkg::tap_t                 in_tap,
  input  im2col_pkg::cfg_t                 cfg,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [im2col_pkg::TAPI_W-1:0]    out_tap_index,
  output logic                             out_padding,
  output logic [im2col_pkg::ADDR_W-1:0]    out_addr,
  output logic                             out_last
);

  localparam int LIN_W = 20;
  localparam int HW_W  = 2 * im2col_pkg::IMG_W;
  localparam int PB_W  = im2col_pkg::PLANE_W + HW_W;

  logic en1, en2, en3;

  // stage 1
  logic                              v1;
  logic [im2col_pkg::PLANE_W-1:0]    plane1;
  logic [HW_W-1:0]                   hw1;
  logic signed [LIN_W:0]             ir1, ic1;
  logic [im2col_pkg::TAPI_W-1:0]     tapi1;
  logic                              last1;

  // stage 2
  logic                              v2;
  logic [im2col_pkg::ADDR_W-1:0]     pb2;
  logic [im2col_pkg::IMG_W-1:0]      ir2, ic2;
  logic                              inside2;
  logic [im2col_pkg::TAPI_W-1:0]     tapi2;
  logic                              last2;

  logic [LIN_W-1:0] row_pos, col_pos;
  logic             row_in, col_in;
  logic [im2col_pkg::ADDR_W-1:0] addr_sum;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    row_pos = LIN_W'(in_tap.out_row) * LIN_W'(cfg.stride_rows)
            + LIN_W'(in_tap.tap_row) * LIN_W'(DILATION_ROWS);
    col_pos = LIN_W'(in_tap.out_col) * LIN_W'(cfg.stride_cols)
            + LIN_W'(in_tap.tap_col) * LIN_W'(DILATION_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      plane1 <= in_tap.plane_index;
      hw1    <= HW_W'(cfg.image_height) * HW_W'(cfg.image_width);
      ir1    <= $signed({1'b0, row_pos}) - $signed((LIN_W + 1)'(cfg.pad_rows));
      ic1    <= $signed({1'b0, col_pos}) - $signed((LIN_W + 1)'(cfg.pad_cols));
      tapi1  <= im2col_pkg::TAPI_W'(im2col_pkg::TAPI_W'(in_tap.tap_row)
                * im2col_pkg::TAPI_W'(cfg.kernel_width)
                + im2col_pkg::TAPI_W'(in_tap.tap_col));
      last1  <= in_tap.last;
    end
  end

  always_comb begin
    row_in = !ir1[LIN_W] && (ir1[LIN_W-1:0] < LIN_W'(cfg.image_height));
    col_in = !ic1[LIN_W] && (ic1[LIN_W-1:0] < LIN_W'(cfg.image_width));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      pb2     <= im2col_pkg::ADDR_W'(PB_W'(plane1) * PB_W'(hw1));
      ir2     <= ir1[im2col_pkg::IMG_W-1:0];
      ic2     <= ic1[im2col_pkg::IMG_W-1:0];
      inside2 <= row_in && col_in;
      tapi2   <= tapi1;
      last2   <= last1;
    end
  end

  // stage 3: row offset and final sum, output register
  assign addr_sum = pb2
                  + im2col_pkg::ADDR_W'(HW_W'(ir2) * HW_W'(cfg.image_width))
                  + im2col_pkg::ADDR_W'(ic2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3) begin
      out_addr      <= inside2 ? addr_sum : '0;
      out_padding   <= !inside2;
      out_tap_index <= tapi2;
      out_last      <= last2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/im2col_patch_address_generator_unit.sv -----
// im2col patch address generator: one tap address per cycle unless stalled by backpressure, kernel row major.
// a new item is taken only when the tap sequencer is idle or issuing its last tap.
// the address pipeline takes a tap every cycle; results stall in place on backpressure.
// reset (rst, synchronous): registers take their reset values, pipeline and sequencer empty.
// depends on im2col_pkg and im2col_addr_pipe
`default_nettype none

module im2col_patch_address_generator_unit #(
  parameter int MAX_KERNEL    = im2col_pkg::MAX_KERNEL_DEF,
  parameter int DILATION_ROWS = im2col_pkg::DILATION_ROWS_DEF,
  parameter int DILATION_COLS = im2col_pkg::DILATION_COLS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // apb configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [im2col_pkg::APB_AW-1:0]    paddr,
  input  wire  [im2col_pkg::APB_DW-1:0]    pwdata,
  output logic [im2col_pkg::APB_DW-1:0]    prdata,
  output logic                             pready,
  // input stream
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [39:0]                      s_tdata,  // plane_index[15:0], out_row[27:16], out_col[39:28]
  // output stream
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [47:0]                      m_tdata,  // tap_index[5:0], source_address[45:6], zero
  output logic                             m_tuser,  // is_padding
  output logic                             m_tlast   // last_tap
);

  logic [im2col_pkg::KER_W-1:0] kernel_height, kernel_width;
  logic [im2col_pkg::STR_W-1:0] stride_rows, stride_cols;
  logic [im2col_pkg::PAD_W-1:0] pad_rows, pad_cols;
  logic [im2col_pkg::IMG_W-1:0] image_height, image_width;

  logic [im2col_pkg::KER_W-1:0] kh_eff, kw_eff;
  logic                         cfg_wr;
  im2col_pkg::cfg_t             cfg;

  logic                             busy;
  logic [im2col_pkg::PLANE_W-1:0]   plane;
  logic [im2col_pkg::POS_W-1:0]     orow, ocol;
  logic [im2col_pkg::TAP_W-1:0]     tap_row, tap_col;
  logic                             tap_last, row_end;
  logic                             pipe_ready;
  im2col_pkg::tap_t                 tap;

  logic [im2col_pkg::TAPI_W-1:0]    out_tap_index;
  logic [im2col_pkg::ADDR_W-1:0]    out_addr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= im2col_pkg::KER_W'(3);
      kernel_width  <= im2col_pkg::KER_W'(3);
      stride_rows   <= im2col_pkg::STR_W'(1);
      stride_cols   <= im2col_pkg::STR_W'(1);
      pad_rows      <= '0;
      pad_cols      <= '0;
      image_height  <= im2col_pkg::IMG_W'(1);
      image_width   <= im2col_pkg::IMG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        im2col_pkg::REG_KERNEL_HEIGHT: kernel_height <= pwdata[im2col_pkg::KER_W-1:0];
        im2col_pkg::REG_KERNEL_WIDTH:  kernel_width  <= pwdata[im2col_pkg::KER_W-1:0];
        im2col_pkg::REG_STRIDE_ROWS:   stride_rows   <= pwdata[im2col_pkg::STR_W-1:0];
        im2col_pkg::REG_STRIDE_COLS:   stride_cols   <= pwdata[im2col_pkg::STR_W-1:0];
        im2col_pkg::REG_PAD_ROWS:      pad_rows      <= pwdata[im2col_pkg::PAD_W-1:0];
        im2col_pkg::REG_PAD_COLS:      pad_cols      <= pwdata[im2col_pkg::PAD_W-1:0];
        im2col_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[im2col_pkg::IMG_W-1:0];
        im2col_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[im2col_pkg::IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      im2col_pkg::REG_KERNEL_HEIGHT: prdata = im2col_pkg::APB_DW'(kernel_height);
      im2col_pkg::REG_KERNEL_WIDTH:  prdata = im2col_pkg::APB_DW'(kernel_width);
      im2col_pkg::REG_STRIDE_ROWS:   prdata = im2col_pkg::APB_DW'(stride_rows);
      im2col_pkg::REG_STRIDE_COLS:   prdata = im2col_pkg::APB_DW'(stride_cols);
      im2col_pkg::REG_PAD_ROWS:      prdata = im2col_pkg::APB_DW'(pad_rows);
      im2col_pkg::REG_PAD_COLS:      prdata = im2col_pkg::APB_DW'(pad_cols);
      im2col_pkg::REG_IMAGE_HEIGHT:  prdata = im2col_pkg::APB_DW'(image_height);
      im2col_pkg::REG_IMAGE_WIDTH:   prdata = im2col_pkg::APB_DW'(image_width);
      default:                       prdata = '0;
    endcase
  end

  // kernel size clamped to 1..MAX_KERNEL
  always_comb begin
    kh_eff = kernel_height;
    if (kernel_height == '0) begin
      kh_eff = im2col_pkg::KER_W'(1);
    end else if (kernel_height > im2col_pkg::KER_W'(MAX_KERNEL)) begin
      kh_eff = im2col_pkg::KER_W'(MAX_KERNEL);
    end
    kw_eff = kernel_width;
    if (kernel_width == '0) begin
      kw_eff = im2col_pkg::KER_W'(1);
    end else if (kernel_width > im2col_pkg::KER_W'(MAX_KERNEL)) begin
      kw_eff = im2col_pkg::KER_W'(MAX_KERNEL);
    end
  end

  assign cfg.kernel_width = kw_eff;
  assign cfg.stride_rows  = stride_rows;
  assign cfg.stride_cols  = stride_cols;
  assign cfg.pad_rows     = pad_rows;
  assign cfg.pad_cols     = pad_cols;
  assign cfg.image_height = image_height;
  assign cfg.image_width  = image_width;

  // tap sequencer
  assign row_end  = (im2col_pkg::KER_W'(tap_col) + im2col_pkg::KER_W'(1)) == kw_eff;
  assign tap_last = row_end
                 && ((im2col_pkg::KER_W'(tap_row) + im2col_pkg::KER_W'(1)) == kh_eff);
  assign s_tready = !busy || (pipe_ready && tap_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      tap_row <= '0;
      tap_col <= '0;
    end else if (s_tvalid && s_tready) begin
      busy    <= 1'b1;
      tap_row <= '0;
      tap_col <= '0;
    end else if (busy && pipe_ready) begin
      if (tap_last) begin
        busy    <= 1'b0;
        tap_row <= '0;
        tap_col <= '0;
      end else if (row_end) begin
        tap_col <= '0;
        tap_row <= tap_row + im2col_pkg::TAP_W'(1);
      end else begin
        tap_col <= tap_col + im2col_pkg::TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      plane <= s_tdata[15:0];
      orow  <= s_tdata[27:16];
      ocol  <= s_tdata[39:28];
    end
  end

  assign tap.plane_index = plane;
  assign tap.out_row     = orow;
  assign tap.out_col     = ocol;
  assign tap.tap_row     = tap_row;
  assign tap.tap_col     = tap_col;
  assign tap.last        = tap_last;

  im2col_addr_pipe #(
    .DILATION_ROWS (DILATION_ROWS),
    .DILATION_COLS (DILATION_COLS)
  ) u_pipe (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (busy),
    .in_ready      (pipe_ready),
    .in_tap        (tap),
    .cfg           (cfg),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_tap_index (out_tap_index),
    .out_padding   (m_tuser),
    .out_addr      (out_addr),
    .out_last      (m_tlast)
  );

  assign m_tdata = {2'b00, out_addr, out_tap_index};

`ifndef SYNTH
  a_pad_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[45:6] == '0)
    else $error("padding tap with nonzero address");

  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> busy && tap_row == '0 && tap_col == '0)
    else $error("tap walk did not start at tap zero");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !pipe_ready |=> busy && $stable(tap_row) && $stable(tap_col))
    else $error("tap counters moved during stall");

  a_tap_in_kernel: assert property (@(posedge clk) disable iff (rst)
    busy |-> (im2col_pkg::KER_W'(tap_row) < kh_eff) && (im2col_pkg::KER_W'(tap_col) < kw_eff))
    else $error("tap counter outside kernel");
`endif

endmodule

`default_nettype wire
